### src/mfpd_pkg.sv
// shared types and constants of the magic framed packet deframer
package mfpd_pkg;

	localparam logic [31:0] HEAD_MAGIC_RESET = 32'h9D74C714;
	localparam logic [31:0] TAIL_MAGIC_RESET = 32'hD7A152C8;
	localparam int unsigned FIXED_HEADER_BYTES = 12;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_MAGIC = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_MAGIC = 1'd1;

	localparam int unsigned RESULT_QUEUE_DEPTH = 4;

	localparam logic ITEM_BODY = 1'b0;
	localparam logic ITEM_VERDICT = 1'b1;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_BAD_HEAD = 2'd1;
	localparam logic [1:0] STATUS_SHORT = 2'd2;
	localparam logic [1:0] STATUS_BAD_TAIL = 2'd3;

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  body_byte;
		logic        body_last;
		logic [1:0]  status;
		logic [15:0] command_id;
		logic [31:0] body_length;
	} result_t;

endpackage

### src/mfpd_if.sv
// byte input and result output channel interfaces
interface mfpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       buffer_end;

	modport source(output valid, data_byte, buffer_end, input ready);
	modport sink(input valid, data_byte, buffer_end, output ready);
endinterface

interface mfpd_out_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic [7:0]  body_byte;
	logic        body_last;
	logic [1:0]  status;
	logic [15:0] command_id;
	logic [31:0] body_length;

	modport source(output valid, item_kind, body_byte, body_last, status, command_id,
		body_length, input ready);
	modport sink(input valid, item_kind, body_byte, body_last, status, command_id,
		body_length, output ready);
endinterface

### src/magic_framed_packet_deframer_unit.sv
// top level of the magic framed packet deframer
//
// din takes one buffer byte per transaction, buffer_end set on the final byte.
// The block checks the head magic, reads command id, extension size and body
// size, skips the extension, passes body bytes out on dout (item_kind 0,
// body_last on the final one), checks the tail magic and sends one verdict
// (item_kind 1) per buffer. A buffer that ends before its verdict gets a
// too-short verdict; bytes after the tail are ignored.
// Each byte is parsed in the cycle it is accepted and its results land in a
// small result queue. Throughput is one byte per cycle while din.ready is
// high, that is while the queue has room for two results, so a stalled
// receiver lets the queue fill and then holds off the sender. The only byte
// that yields two results is a body byte that also ends the buffer, and the
// queue drains one result per cycle while dout.ready is high. Magic registers
// are written through cfg_we/cfg_index/cfg_data while idle, a rule the block
// leaves to the user. Reset (arst_n low) empties the queue, returns the parser
// to await a head magic and loads the default magic values.
module magic_framed_packet_deframer_unit #(
	parameter int unsigned QUEUE_DEPTH = mfpd_pkg::RESULT_QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfpd_pkg::CFG_DATA_W-1:0] cfg_data,
	mfpd_in_if.sink                        din,
	mfpd_out_if.source                     dout
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	localparam logic [2:0] PH_HEAD = 3'd0;
	localparam logic [2:0] PH_HDR  = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_BODY = 3'd3;
	localparam logic [2:0] PH_TAIL = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;

	localparam logic [31:0] HDR_FIELD_BYTES = 32'(mfpd_pkg::FIXED_HEADER_BYTES - 4);

	logic [31:0] head_magic_q, tail_magic_q;
	logic [2:0]  phase_q, phase_n;
	logic [31:0] count_q, count_n;
	logic [31:0] shift_q, shift_n;
	logic [15:0] cmd_q, cmd_n;
	logic [15:0] ext_q, ext_n;
	logic [31:0] body_q, body_n;
	logic        given_q, given_n;

	mfpd_pkg::result_t res [2];
	logic [1:0]        res_v;
	logic              verdict_push;

	mfpd_pkg::result_t queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q, wr_ptr_1;
	logic [CNT_W-1:0]  fill_q;

	logic accept, pop;
	logic [31:0] count_inc, shift_in;

	assign accept = din.valid && din.ready;
	assign pop = dout.valid && dout.ready;
	assign din.ready = (fill_q <= CNT_W'(QUEUE_DEPTH - 2));

	assign count_inc = count_q + 32'd1;
	assign shift_in = {shift_q[23:0], din.data_byte};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_magic_q <= mfpd_pkg::HEAD_MAGIC_RESET;
			tail_magic_q <= mfpd_pkg::TAIL_MAGIC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mfpd_pkg::REG_HEAD_MAGIC: head_magic_q <= cfg_data;
				mfpd_pkg::REG_TAIL_MAGIC: tail_magic_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// parser for one byte
	always_comb begin
		mfpd_pkg::result_t verdict;
		logic [1:0]        vstatus;
		logic              vgen;

		phase_n = phase_q;
		count_n = count_q;
		shift_n = shift_q;
		cmd_n = cmd_q;
		ext_n = ext_q;
		body_n = body_q;
		given_n = given_q;
		vgen = 1'b0;
		vstatus = mfpd_pkg::STATUS_OK;

		res[0] = '0;
		res[1] = '0;
		res_v = 2'b00;

		case (phase_q)
			PH_HEAD: begin
				shift_n = shift_in;
				count_n = count_inc;
				if (count_inc == 32'd4) begin
					if (shift_in != head_magic_q) begin
						vgen = 1'b1;
						vstatus = mfpd_pkg::STATUS_BAD_HEAD;
					end else begin
						phase_n = PH_HDR;
						count_n = '0;
						shift_n = '0;
					end
				end
			end
			PH_HDR: begin
				shift_n = shift_in;
				count_n = count_inc;
				if (count_inc == 32'd2) begin
					cmd_n = shift_in[15:0];
					shift_n = '0;
				end else if (count_inc == 32'd4) begin
					ext_n = shift_in[15:0];
					shift_n = '0;
				end else if (count_inc == HDR_FIELD_BYTES) begin
					body_n = shift_in;
					shift_n = '0;
					count_n = '0;
					if (ext_q != 16'd0) begin
						phase_n = PH_EXT;
					end else begin
						phase_n = (shift_in != 32'd0) ? PH_BODY : PH_TAIL;
					end
				end
			end
			PH_EXT: begin
				count_n = count_inc;
				if (count_inc >= {16'd0, ext_q}) begin
					count_n = '0;
					phase_n = (body_q != 32'd0) ? PH_BODY : PH_TAIL;
				end
			end
			PH_BODY: begin
				count_n = count_inc;
				res_v[0] = 1'b1;
				res[0].item_kind = mfpd_pkg::ITEM_BODY;
				res[0].body_byte = din.data_byte;
				res[0].body_last = (count_inc >= body_q);
				if (count_inc >= body_q) begin
					phase_n = PH_TAIL;
					count_n = '0;
					shift_n = '0;
				end
			end
			PH_TAIL: begin
				shift_n = shift_in;
				count_n = count_inc;
				if (count_inc == 32'd4) begin
					vgen = 1'b1;
					vstatus = (shift_in == tail_magic_q) ? mfpd_pkg::STATUS_OK :
						mfpd_pkg::STATUS_BAD_TAIL;
				end
			end
			default: ;
		endcase

		// buffer ended before any verdict
		if (din.buffer_end && !given_q && !vgen) begin
			vgen = 1'b1;
			vstatus = mfpd_pkg::STATUS_SHORT;
		end

		verdict = '0;
		verdict.item_kind = mfpd_pkg::ITEM_VERDICT;
		verdict.status = vstatus;
		if (vstatus == mfpd_pkg::STATUS_OK) begin
			verdict.command_id = cmd_q;
			verdict.body_length = body_q;
		end

		if (vgen) begin
			given_n = 1'b1;
			phase_n = PH_DONE;
			if (res_v[0]) begin
				res[1] = verdict;
				res_v[1] = 1'b1;
			end else begin
				res[0] = verdict;
				res_v[0] = 1'b1;
			end
		end
		verdict_push = vgen;

		if (din.buffer_end) begin
			phase_n = PH_HEAD;
			count_n = '0;
			shift_n = '0;
			cmd_n = '0;
			ext_n = '0;
			body_n = '0;
			given_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			count_q <= '0;
			shift_q <= '0;
			cmd_q <= '0;
			ext_q <= '0;
			body_q <= '0;
			given_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			count_q <= count_n;
			shift_q <= shift_n;
			cmd_q <= cmd_n;
			ext_q <= ext_n;
			body_q <= body_n;
			given_q <= given_n;
		end
	end

	// result queue, up to two writes and one read per cycle
	assign wr_ptr_1 = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (accept && res_v[0]) begin
			queue_q[wr_ptr_q] <= res[0];
		end
		if (accept && res_v[1]) begin
			queue_q[wr_ptr_1] <= res[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic [CNT_W-1:0] n_wr;
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			n_wr = accept ? (CNT_W'(res_v[0]) + CNT_W'(res_v[1])) : '0;
			if (accept && res_v[1]) begin
				wr_ptr_q <= (wr_ptr_1 == LAST_PTR) ? '0 : wr_ptr_1 + PTR_W'(1);
			end else if (accept && res_v[0]) begin
				wr_ptr_q <= wr_ptr_1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_q + n_wr - CNT_W'(pop);
		end
	end

	assign dout.valid = (fill_q != '0);
	assign dout.item_kind = queue_q[rd_ptr_q].item_kind;
	assign dout.body_byte = queue_q[rd_ptr_q].body_byte;
	assign dout.body_last = queue_q[rd_ptr_q].body_last;
	assign dout.status = queue_q[rd_ptr_q].status;
	assign dout.command_id = queue_q[rd_ptr_q].command_id;
	assign dout.body_length = queue_q[rd_ptr_q].body_length;

	// queue never overflows
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(QUEUE_DEPTH))
		else $error("result queue overflow");

	// buffer end always returns the parser to idle
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && din.buffer_end |=> phase_q == PH_HEAD && !given_q && count_q == '0)
		else $error("parser not idle after buffer end");

	// a verdict mid-buffer parks the parser until the buffer ends
	a_verdict_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && verdict_push && !din.buffer_end |=> phase_q == PH_DONE && given_q)
		else $error("verdict given without entering done");

	// at most one verdict per buffer
	a_one_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		accept && given_q |-> !verdict_push)
		else $error("second verdict in one buffer");

endmodule
